@@ design/hnsd_pkg.sv @@
// shared types, constants and helper functions of the head nod and shake detector
`default_nettype none

package hnsd_pkg;

    localparam int ANGLE_FRAC_BITS = 4;
    localparam int ANGLE_W = 13;
    localparam int MOVE_W = 12;
    localparam int FRAC_W = 10;
    localparam int BOUND_W = 15;
    localparam int CALC_W = 16;
    localparam int GEST_W = 2;
    localparam int FLAG_W = 4;

    localparam logic [MOVE_W-1:0] MOVE_ANGLE_RESET = 12'd480;
    localparam logic signed [CALC_W-1:0] FULL_TURN = CALC_W'(360 << ANGLE_FRAC_BITS);

    localparam logic [GEST_W-1:0] GEST_NONE = 2'd0;
    localparam logic [GEST_W-1:0] GEST_SHAKE = 2'd1;
    localparam logic [GEST_W-1:0] GEST_NOD = 2'd2;

    localparam int FLAG_RIGHT = 0;
    localparam int FLAG_LEFT = 1;
    localparam int FLAG_DOWN = 2;
    localparam int FLAG_UP = 3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic [MOVE_W-1:0] move_angle;
        logic [FRAC_W-1:0] quarter;
        logic [FRAC_W-1:0] sixth;
    } thresh_t;

    typedef logic signed [BOUND_W-1:0] bound_t;

    // floor(m / 6) as floor((m >> 1) * 2731 >> 13), exact for 11-bit halves
    function automatic logic [FRAC_W-1:0] div6(input logic [MOVE_W-1:0] m);
        logic [MOVE_W-2:0] h;
        logic [23:0] p;
        h = m[MOVE_W-1:1];
        p = {13'd0, h} * 24'd2731;
        return p[13+FRAC_W-1:13];
    endfunction

    // shift a sample by a full turn when it sits across the seam from the centre
    function automatic logic signed [CALC_W-1:0] unwrap(
        input logic [ANGLE_W-1:0] sample,
        input logic [ANGLE_W-1:0] centre,
        input logic [MOVE_W-1:0] m
    );
        logic signed [CALC_W-1:0] s;
        logic signed [CALC_W-1:0] c;
        logic signed [CALC_W-1:0] mm;
        logic signed [CALC_W-1:0] lim;
        s = $signed({{(CALC_W-ANGLE_W){1'b0}}, sample});
        c = $signed({{(CALC_W-ANGLE_W){1'b0}}, centre});
        mm = $signed({{(CALC_W-MOVE_W){1'b0}}, m});
        lim = FULL_TURN - mm;
        if (lim < c && s < mm)
            return s + FULL_TURN;
        else if (mm > c && s > lim)
            return s - FULL_TURN;
        else
            return s;
    endfunction

endpackage

`default_nettype wire

@@ design/hnsd_if.sv @@
// valid/ready channel interfaces for samples, results and the threshold write
`default_nettype none

interface hnsd_in_if;
    logic valid;
    logic ready;
    logic func;
    logic [hnsd_pkg::ANGLE_W-1:0] yaw_angle;
    logic [hnsd_pkg::ANGLE_W-1:0] pitch_angle;

    modport source (output valid, func, yaw_angle, pitch_angle, input ready);
    modport sink (input valid, func, yaw_angle, pitch_angle, output ready);
endinterface

interface hnsd_out_if;
    logic valid;
    logic ready;
    logic [hnsd_pkg::GEST_W-1:0] gesture;
    logic armed_now;

    modport source (output valid, gesture, armed_now, input ready);
    modport sink (input valid, gesture, armed_now, output ready);
endinterface

interface hnsd_cfg_if;
    logic valid;
    logic ready;
    logic [hnsd_pkg::MOVE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/hnsd_cfg.sv @@
// threshold register and the bound offsets derived from it
`default_nettype none

module hnsd_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    hnsd_cfg_if.sink          cfg,
    output hnsd_pkg::thresh_t thr
);
    import hnsd_pkg::*;

    logic [MOVE_W-1:0] move_angle_reg;
    logic [MOVE_W-1:0] move_angle_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        move_angle_next = move_angle_reg;
        if (cfg.valid)
            move_angle_next = cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            move_angle_reg <= MOVE_ANGLE_RESET;
        else
            move_angle_reg <= move_angle_next;
    end

    assign thr.move_angle = move_angle_reg;
    assign thr.quarter = move_angle_reg[MOVE_W-1:2];
    assign thr.sixth = div6(move_angle_reg);

endmodule

`default_nettype wire

@@ design/hnsd_core.sv @@
// detection state: centre, bounds, side flags and the gesture decision
`default_nettype none

module hnsd_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            func,
    input  wire logic [hnsd_pkg::ANGLE_W-1:0]    yaw_angle,
    input  wire logic [hnsd_pkg::ANGLE_W-1:0]    pitch_angle,
    input  wire hnsd_pkg::thresh_t               thr,
    output logic      [hnsd_pkg::GEST_W-1:0]     gesture,
    output logic                                 armed_now
);
    import hnsd_pkg::*;

    logic               armed_reg, armed_next;
    logic [ANGLE_W-1:0] centre_yaw_reg, centre_yaw_next;
    logic [ANGLE_W-1:0] centre_pitch_reg, centre_pitch_next;
    bound_t             right_reg, right_next;
    bound_t             left_reg, left_next;
    bound_t             down_reg, down_next;
    bound_t             up_reg, up_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;

    logic signed [CALC_W-1:0] yaw_s, pitch_s, quarter_s, sixth_s;
    logic signed [CALC_W-1:0] z, y;
    logic signed [CALC_W-1:0] rc_right, rc_left, rc_down, rc_up;
    logic [FLAG_W-1:0]        fl;

    assign yaw_s = $signed({{(CALC_W-ANGLE_W){1'b0}}, yaw_angle});
    assign pitch_s = $signed({{(CALC_W-ANGLE_W){1'b0}}, pitch_angle});
    assign quarter_s = $signed({{(CALC_W-FRAC_W){1'b0}}, thr.quarter});
    assign sixth_s = $signed({{(CALC_W-FRAC_W){1'b0}}, thr.sixth});

    // recentred bounds on the raw sample angles
    assign rc_right = yaw_s + quarter_s;
    assign rc_left = yaw_s - quarter_s;
    assign rc_down = pitch_s - quarter_s;
    assign rc_up = pitch_s + sixth_s;

    assign z = unwrap(yaw_angle, centre_yaw_reg, thr.move_angle);
    assign y = unwrap(pitch_angle, centre_pitch_reg, thr.move_angle);

    always_comb
    begin
        armed_next = armed_reg;
        centre_yaw_next = centre_yaw_reg;
        centre_pitch_next = centre_pitch_reg;
        right_next = right_reg;
        left_next = left_reg;
        down_next = down_reg;
        up_next = up_reg;
        flags_next = flags_reg;
        fl = flags_reg;
        gesture = GEST_NONE;

        if (func == FUNC_START)
        begin
            armed_next = 1'b1;
            centre_yaw_next = yaw_angle;
            centre_pitch_next = pitch_angle;
            right_next = rc_right[BOUND_W-1:0];
            left_next = rc_left[BOUND_W-1:0];
            down_next = rc_down[BOUND_W-1:0];
            up_next = rc_up[BOUND_W-1:0];
            flags_next = '0;
        end
        else if (armed_reg)
        begin
            if (z > CALC_W'(right_reg))
            begin
                right_next = z[BOUND_W-1:0];
                fl[FLAG_RIGHT] = 1'b1;
            end
            else if (z < CALC_W'(left_reg))
            begin
                left_next = z[BOUND_W-1:0];
                fl[FLAG_LEFT] = 1'b1;
            end

            if (y < CALC_W'(down_reg))
            begin
                down_next = y[BOUND_W-1:0];
                fl[FLAG_DOWN] = 1'b1;
            end
            else if (y > CALC_W'(up_reg))
            begin
                up_next = y[BOUND_W-1:0];
                fl[FLAG_UP] = 1'b1;
            end

            flags_next = fl;
            if (fl[FLAG_RIGHT] && fl[FLAG_LEFT])
                gesture = GEST_SHAKE;
            else if (fl[FLAG_DOWN] && fl[FLAG_UP])
                gesture = GEST_NOD;

            // report: recentre on this sample and disarm
            if (gesture != GEST_NONE)
            begin
                armed_next = 1'b0;
                centre_yaw_next = yaw_angle;
                centre_pitch_next = pitch_angle;
                right_next = rc_right[BOUND_W-1:0];
                left_next = rc_left[BOUND_W-1:0];
                down_next = rc_down[BOUND_W-1:0];
                up_next = rc_up[BOUND_W-1:0];
                flags_next = '0;
            end
        end
    end

    assign armed_now = armed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            centre_yaw_reg <= '0;
            centre_pitch_reg <= '0;
            right_reg <= '0;
            left_reg <= '0;
            down_reg <= '0;
            up_reg <= '0;
            flags_reg <= '0;
        end
        else if (en)
        begin
            armed_reg <= armed_next;
            centre_yaw_reg <= centre_yaw_next;
            centre_pitch_reg <= centre_pitch_next;
            right_reg <= right_next;
            left_reg <= left_next;
            down_reg <= down_next;
            up_reg <= up_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

@@ design/head_nod_shake_detector_unit.sv @@
// top level of the head nod and shake detector with input and result registers
`default_nettype none

// Takes one sample or start beat per clock while the result channel is ready, and gives
// exactly one result beat for each. A beat is held in the input register, judged
// against the detection state from there and captured in the result register, which
// drives the result channel; a full result register that is not taken stalls the input
// register. Sustained throughput is one beat per clock while result ready stays high;
// the state update (unwrap, bound compare, flag decision) is combinational from the input
// register. Sample ready follows result ready combinationally when both registers are
// full. The threshold is written through the configuration channel, which is always
// ready, and should only change while no beat is in flight.
module head_nod_shake_detector_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hnsd_in_if.sink    sample,
    hnsd_out_if.source result,
    hnsd_cfg_if.sink   cfg
);
    import hnsd_pkg::*;

    thresh_t thr;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_func_reg;
    logic [ANGLE_W-1:0] s1_yaw_reg;
    logic [ANGLE_W-1:0] s1_pitch_reg;
    logic               out_valid_reg, out_valid_next;
    logic [GEST_W-1:0]  gesture_reg;
    logic               armed_reg;

    logic               advance;
    logic               take;
    logic [GEST_W-1:0]  core_gesture;
    logic               core_armed;

    hnsd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .thr   (thr)
    );

    hnsd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .func        (s1_func_reg),
        .yaw_angle   (s1_yaw_reg),
        .pitch_angle (s1_pitch_reg),
        .thr         (thr),
        .gesture     (core_gesture),
        .armed_now   (core_armed)
    );

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take = sample.valid && sample.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_func_reg <= sample.func;
            s1_yaw_reg <= sample.yaw_angle;
            s1_pitch_reg <= sample.pitch_angle;
        end
        if (advance)
        begin
            gesture_reg <= core_gesture;
            armed_reg <= core_armed;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.gesture = gesture_reg;
    assign result.armed_now = armed_reg;

endmodule

`default_nettype wire
